>>> rtl/upd_pkg.sv
package upd_pkg;

  // Decoder phase codes.
  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_PCT   = 3'd1;
  localparam logic [2:0] PH_HEX2  = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;

  // Characters with a special meaning in the encoded string.
  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_U     = 8'h75;

  // Bytes dropped after the 'u' of a unicode escape.
  localparam logic [2:0] SKIP_BYTES = 3'd4;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] skip_left;
    logic [3:0] high_nibble;
    logic       failed;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase:       PH_PLAIN,
    skip_left:   3'd0,
    high_nibble: 4'd0,
    failed:      1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic       ok;
  } dec_result_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

>>> rtl/upd_step.sv
module upd_step (
  input  upd_pkg::dec_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output upd_pkg::dec_state_t  state_o,
  output upd_pkg::dec_result_t result_o
);

  upd_pkg::dec_state_t nxt;
  logic [7:0]          ob;
  logic                vld;
  logic [4:0]          hex;

  assign hex = upd_pkg::hex_digit(byte_i);

  always_comb begin
    nxt = state_i;
    ob  = 8'd0;
    vld = 1'b0;
    if (!state_i.failed) begin
      case (state_i.phase)
        upd_pkg::PH_PCT: begin
          if (byte_i == upd_pkg::CHR_U) begin
            nxt.phase     = upd_pkg::PH_SKIP;
            nxt.skip_left = upd_pkg::SKIP_BYTES;
          end else if (!hex[4]) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.high_nibble = hex[3:0];
            nxt.phase       = upd_pkg::PH_HEX2;
            if (last_i) begin
              nxt.failed = 1'b1;
            end
          end
        end
        upd_pkg::PH_HEX2: begin
          if (!hex[4]) begin
            nxt.failed = 1'b1;
          end else begin
            ob        = {state_i.high_nibble, hex[3:0]};
            vld       = 1'b1;
            nxt.phase = upd_pkg::PH_PLAIN;
          end
        end
        upd_pkg::PH_SKIP: begin
          nxt.skip_left = state_i.skip_left - 3'd1;
          if (nxt.skip_left == 3'd0) begin
            nxt.phase = upd_pkg::PH_PLAIN;
          end
        end
        default: begin
          // Plain text, and any phase code that should never occur.
          if (byte_i == upd_pkg::CHR_PCT) begin
            nxt.phase = upd_pkg::PH_PCT;
            if (last_i) begin
              nxt.failed = 1'b1;
            end
          end else if (byte_i == upd_pkg::CHR_PLUS) begin
            ob  = upd_pkg::CHR_SPACE;
            vld = 1'b1;
          end else begin
            ob  = byte_i;
            vld = 1'b1;
          end
        end
      endcase
      if (nxt.failed) begin
        ob  = 8'd0;
        vld = 1'b0;
      end
    end
  end

  always_comb begin
    result_o.out_byte  = ob;
    result_o.out_valid = vld;
    result_o.done_res  = last_i;
    result_o.ok        = last_i & ~nxt.failed;
    state_o            = last_i ? upd_pkg::STATE_RESET : nxt;
  end

endmodule

>>> rtl/url_percent_decoder_top.sv
// Channel   Handshake                  Payload
// -------   -------------------------  ---------------------------------------
// input     in_valid_i / in_ready_o    in_byte_i[7:0], in_last_i
// result    res_valid_o / res_ready_i  out_byte_o[7:0], out_valid_o,
//                                      done_res_o, ok_o
//
// Every input word gives exactly one result word. A word waits in the input
// register and is decoded on its way into the result register; the block
// takes one word per cycle while the result channel is not stalled.
// The decoder state advances only when a word moves into the result register.
// A stalled result holds; the input register still takes one more word.
// Reset puts both registers empty and the decoder in plain text phase.
module url_percent_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       done_res_o,
  output logic       ok_o
);

  // Input register: a word waits here until the result register is free.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic                 res_vld_q;
  upd_pkg::dec_result_t res_q;

  // Decoder state, updated once per decoded word.
  upd_pkg::dec_state_t  state_q;
  upd_pkg::dec_state_t  state_d;
  upd_pkg::dec_result_t res_d;

  logic advance;
  logic in_fire;

  // The decoded word moves on when the result register is empty or being
  // drained in this same cycle.
  assign advance    = in_vld_q & (~res_vld_q | res_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;

  upd_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= upd_pkg::STATE_RESET;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign out_byte_o  = res_q.out_byte;
  assign out_valid_o = res_q.out_valid;
  assign done_res_o  = res_q.done_res;
  assign ok_o        = res_q.ok;

  // A string's final word always leaves the decoder in its reset state.
  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> state_q == upd_pkg::STATE_RESET)
    else $error("decoder state not cleared after last word");

  // The ok flag is only reported together with done.
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ok_o |-> done_res_o)
    else $error("ok reported without done");

  // A suppressed character carries a zero byte.
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("nonzero byte on a suppressed character");

  // Input back-pressure only arises when both registers are full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && res_vld_q && !res_ready_i)
    else $error("input stalled without a full pipeline");

endmodule
